// File: design/huffman_code_builder_assert.svh
// Assertion macros used by the checker file of the Huffman code builder.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef HUFFMAN_CODE_BUILDER_ASSERT_SVH
`define HUFFMAN_CODE_BUILDER_ASSERT_SVH

// Same-cycle implication.
`define HCB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HCB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/hcb_pkg.sv
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared widths and defaults of the Huffman code builder.
// ----------------------------------------------------------------------------
`default_nettype none

package hcb_pkg;

  // Port field widths.
  localparam int unsigned InWeightBits  = 24;
  localparam int unsigned SymbolBits    = 5;
  localparam int unsigned CodeBits      = 31;
  localparam int unsigned LengthBits    = 5;

  // Stored node weights wrap at this width.
  localparam int unsigned NodeWeightBits = 29;

  // Depth of the pending-range stack of the sort.
  localparam int unsigned StackDepth = 32;

  // Longest code that is kept.
  localparam int unsigned CodeMax = 31;

  // Parameter defaults.
  localparam int unsigned DefAlphabetSize = 32;
  localparam int unsigned DefWeightBits   = 24;

endpackage

`default_nettype wire

// File: design/hcb_ram.sv
// ----------------------------------------------------------------------------
// hcb_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hcb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: design/huffman_code_builder.sv
// ----------------------------------------------------------------------------
// huffman_code_builder
// Loads one weight per symbol, builds a Huffman tree and emits every code.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  in      | in_valid_i, in_ready_o, weight_i          | weight beats in
//  out     | out_valid_o, out_ready_i, symbol_o,       | one code beat
//          | code_bits_o, code_length_o, last_o        | per symbol out
//
// Weight beats before the last of the alphabet can come back to back.
// The last beat starts the build: each merge round runs a quicksort over the
// live roots in which every weight compare does a root-order read, then the
// weight RAM's registered read. Each code is then built by a walk through
// the link RAM.
// Reset clears the control state only; no clearing pass is needed.
// in_ready_o is low from the last weight until the final code is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_builder
  import hcb_pkg::*;
#(
  parameter int unsigned NUM_SYMBOLS = DefAlphabetSize,
  parameter int unsigned WEIGHT_BITS = DefWeightBits
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [InWeightBits-1:0] weight_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [SymbolBits-1:0]        symbol_o,
  output logic [CodeBits-1:0]          code_bits_o,
  output logic [LengthBits-1:0]        code_length_o,
  output logic                         last_o
);

  localparam int unsigned NodeCount = 2 * NUM_SYMBOLS - 1;
  localparam int unsigned NodeBits  = $clog2(NodeCount);
  localparam int unsigned PosBits   = $clog2(NUM_SYMBOLS);
  localparam int unsigned SpBits    = $clog2(StackDepth + 1);
  localparam int unsigned SpIdxBits = $clog2(StackDepth);
  localparam int unsigned LinkBits  = NodeBits + 1;

  localparam logic [NodeBits-1:0] RootNode = NodeBits'(NodeCount - 1);
  localparam logic [NodeBits-1:0] FirstMerged = NodeBits'(NUM_SYMBOLS);
  localparam logic [PosBits-1:0]  LastPos  = PosBits'(NUM_SYMBOLS - 1);
  localparam logic [PosBits:0]    LastPosW = (PosBits + 1)'(NUM_SYMBOLS - 1);
  localparam logic [31:0] WeightMask = 32'((64'd1 << WEIGHT_BITS) - 64'd1);
  localparam logic [LengthBits-1:0] LenMax = LengthBits'(CodeMax);

  typedef enum logic [4:0] {
    S_LOAD, S_INIT, S_SORT, S_POP, S_PIVOT, S_JCHK, S_JCMP, S_ICHK, S_ICMP,
    S_SWAP, S_SWAP2, S_SWAP3, S_FIN1, S_FIN2, S_FIN3, S_MRG_A, S_MRG_C,
    S_MRG_SUM, S_MRG_LINK, S_WSTART, S_WALK, S_WSTEP, S_OUT
  } state_e;

  typedef struct packed {
    logic [PosBits-1:0] lo;
    logic [PosBits-1:0] hi;
  } range_t;

  state_e state_q;

  logic [PosBits-1:0]        load_cnt_q;
  logic [PosBits-1:0]        first_q;
  logic [NodeBits-1:0]       next_q;
  logic [SpBits-1:0]         sp_q;
  logic [PosBits-1:0]        b_q, e_q, i_q, j_q;
  logic [NodeBits-1:0]       pivot_q, tmp_q, a_q, c_q, p_q;
  logic [NodeWeightBits-1:0] pw_q, sum_q;
  logic [PosBits-1:0]        sym_q;
  logic [CodeBits-1:0]       bits_q;
  logic [LengthBits-1:0]     len_q;

  logic                    out_valid_q;
  logic [SymbolBits-1:0]   symbol_q;
  logic [CodeBits-1:0]     code_bits_q;
  logic [LengthBits-1:0]   code_length_q;
  logic                    last_q;
  logic                    out_load;

  // Root order and sort stack: register files with one read port each.
  logic [NodeBits-1:0] ro_q [NUM_SYMBOLS];
  range_t              stk_q [StackDepth];

  logic [PosBits-1:0]  ro_addr;
  logic [NodeBits-1:0] ro_rd;
  logic                ro_init, ro_we;
  logic [PosBits-1:0]  ro_waddr;
  logic [NodeBits-1:0] ro_wdata;

  logic [SpBits-1:0]    sp_m1;
  range_t               stk_top;
  logic                 stk_we;
  logic [SpIdxBits-1:0] stk_waddr;
  range_t               stk_wdata;

  logic                      w_we;
  logic [NodeBits-1:0]       w_waddr, w_raddr;
  logic [NodeWeightBits-1:0] w_wdata, w_rdata;

  logic                l_we;
  logic [NodeBits-1:0] l_waddr, l_raddr;
  logic [LinkBits-1:0] l_wdata, l_rdata;

  logic [NodeWeightBits-1:0] in_weight;
  logic [PosBits:0]          i_inc, b_inc, first_inc;

  assign ro_rd     = ro_q[ro_addr];
  assign sp_m1     = sp_q - SpBits'(1);
  assign stk_top   = stk_q[sp_m1[SpIdxBits-1:0]];
  assign in_weight = NodeWeightBits'({8'd0, weight_i} & WeightMask);
  assign i_inc     = {1'b0, i_q} + (PosBits + 1)'(1);
  assign b_inc     = {1'b0, b_q} + (PosBits + 1)'(1);
  assign first_inc = {1'b0, first_q} + (PosBits + 1)'(1);

  // The output register takes a new code when it is empty or being drained.
  assign out_load  = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // Address and write control of the root order, stack and both RAMs.
  always_comb begin
    ro_addr   = '0;
    ro_init   = 1'b0;
    ro_we     = 1'b0;
    ro_waddr  = '0;
    ro_wdata  = '0;
    stk_we    = 1'b0;
    stk_waddr = sp_q[SpIdxBits-1:0];
    stk_wdata = '0;
    w_we      = 1'b0;
    w_waddr   = '0;
    w_wdata   = '0;
    w_raddr   = '0;
    l_we      = 1'b0;
    l_waddr   = '0;
    l_wdata   = '0;
    l_raddr   = p_q;
    unique case (state_q)
      S_LOAD: begin
        w_we    = in_valid_i;
        w_waddr = NodeBits'(load_cnt_q);
        w_wdata = in_weight;
      end
      S_INIT: ro_init = 1'b1;
      S_SORT: begin
        stk_we    = 1'b1;
        stk_waddr = '0;
        stk_wdata = '{lo: first_q, hi: LastPos};
      end
      S_POP: begin
        ro_addr = stk_top.lo;
        w_raddr = ro_rd;
      end
      S_JCHK: begin
        ro_addr = j_q;
        w_raddr = ro_rd;
      end
      S_ICHK: begin
        ro_addr = i_q;
        w_raddr = ro_rd;
      end
      S_SWAP: ro_addr = i_q;
      S_SWAP2: begin
        ro_addr  = j_q;
        ro_we    = 1'b1;
        ro_waddr = i_q;
        ro_wdata = ro_rd;
      end
      S_SWAP3: begin
        ro_we    = 1'b1;
        ro_waddr = j_q;
        ro_wdata = tmp_q;
      end
      S_FIN1: begin
        ro_addr  = i_q;
        ro_we    = 1'b1;
        ro_waddr = b_q;
        ro_wdata = ro_rd;
      end
      S_FIN2: begin
        ro_we     = 1'b1;
        ro_waddr  = i_q;
        ro_wdata  = pivot_q;
        stk_we    = (i_inc < {1'b0, e_q}) && (sp_q < SpBits'(StackDepth));
        stk_wdata = '{lo: i_inc[PosBits-1:0], hi: e_q};
      end
      S_FIN3: begin
        stk_we    = (b_inc < {1'b0, i_q}) && (sp_q < SpBits'(StackDepth));
        stk_wdata = '{lo: b_q, hi: i_q - PosBits'(1)};
      end
      S_MRG_A: begin
        ro_addr = first_q;
        w_raddr = ro_rd;
      end
      S_MRG_C: begin
        ro_addr = first_inc[PosBits-1:0];
        w_raddr = ro_rd;
      end
      S_MRG_SUM: begin
        w_we     = 1'b1;
        w_waddr  = next_q;
        w_wdata  = sum_q + w_rdata;
        l_we     = 1'b1;
        l_waddr  = a_q;
        l_wdata  = {next_q, 1'b1};
        ro_we    = 1'b1;
        ro_waddr = first_inc[PosBits-1:0];
        ro_wdata = next_q;
      end
      S_MRG_LINK: begin
        l_we    = 1'b1;
        l_waddr = c_q;
        l_wdata = {next_q, 1'b0};
      end
      default: ;
    endcase
  end

  // Root order and stack storage.
  always_ff @(posedge clk_i) begin
    if (ro_init) begin
      for (int k = 0; k < NUM_SYMBOLS; k++) begin
        ro_q[k] <= NodeBits'(k);
      end
    end else if (ro_we) begin
      ro_q[ro_waddr] <= ro_wdata;
    end
    if (stk_we) begin
      stk_q[stk_waddr] <= stk_wdata;
    end
  end

  // Node weights of leaves and merged nodes.
  hcb_ram #(
    .Width (NodeWeightBits),
    .Depth (NodeCount)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  // Parent index and left-child flag of each node.
  hcb_ram #(
    .Width (LinkBits),
    .Depth (NodeCount)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  // Sequencer: load, sort and merge rounds, code walks, output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_LOAD;
      load_cnt_q    <= '0;
      first_q       <= '0;
      next_q        <= '0;
      sp_q          <= '0;
      b_q           <= '0;
      e_q           <= '0;
      i_q           <= '0;
      j_q           <= '0;
      pivot_q       <= '0;
      tmp_q         <= '0;
      a_q           <= '0;
      c_q           <= '0;
      p_q           <= '0;
      pw_q          <= '0;
      sum_q         <= '0;
      sym_q         <= '0;
      bits_q        <= '0;
      len_q         <= '0;
      out_valid_q   <= 1'b0;
      symbol_q      <= '0;
      code_bits_q   <= '0;
      code_length_q <= '0;
      last_q        <= 1'b0;
    end else begin
      if (out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      if (stk_we && (state_q != S_SORT)) begin
        sp_q <= sp_q + SpBits'(1);
      end
      unique case (state_q)
        S_LOAD: begin
          if (in_valid_i) begin
            if (load_cnt_q == LastPos) begin
              load_cnt_q <= '0;
              state_q    <= S_INIT;
            end else begin
              load_cnt_q <= load_cnt_q + PosBits'(1);
            end
          end
        end
        S_INIT: begin
          first_q <= '0;
          next_q  <= FirstMerged;
          state_q <= S_SORT;
        end
        S_SORT: begin
          sp_q    <= SpBits'(1);
          state_q <= S_POP;
        end
        S_POP: begin
          if (sp_q == '0) begin
            state_q <= S_MRG_A;
          end else begin
            sp_q    <= sp_m1;
            b_q     <= stk_top.lo;
            e_q     <= stk_top.hi;
            i_q     <= stk_top.lo;
            j_q     <= stk_top.hi;
            pivot_q <= ro_rd;
            state_q <= S_PIVOT;
          end
        end
        S_PIVOT: begin
          pw_q    <= w_rdata;
          state_q <= S_JCHK;
        end
        // Scan from the right while the weight is not below the pivot.
        S_JCHK: state_q <= (j_q > i_q) ? S_JCMP : S_ICHK;
        S_JCMP: begin
          if (w_rdata >= pw_q) begin
            j_q     <= j_q - PosBits'(1);
            state_q <= S_JCHK;
          end else begin
            state_q <= S_ICHK;
          end
        end
        // Scan from the left while the weight is not above the pivot.
        S_ICHK: state_q <= (j_q > i_q) ? S_ICMP : S_SWAP;
        S_ICMP: begin
          if (w_rdata <= pw_q) begin
            i_q     <= i_q + PosBits'(1);
            state_q <= S_ICHK;
          end else begin
            state_q <= S_SWAP;
          end
        end
        S_SWAP: begin
          if (j_q > i_q) begin
            tmp_q   <= ro_rd;
            state_q <= S_SWAP2;
          end else begin
            state_q <= S_FIN1;
          end
        end
        S_SWAP2: state_q <= S_SWAP3;
        S_SWAP3: state_q <= S_JCHK;
        S_FIN1:  state_q <= S_FIN2;
        S_FIN2:  state_q <= S_FIN3;
        S_FIN3:  state_q <= S_POP;
        // Merge the two smallest roots into a new node.
        S_MRG_A: begin
          a_q     <= ro_rd;
          state_q <= S_MRG_C;
        end
        S_MRG_C: begin
          c_q     <= ro_rd;
          sum_q   <= w_rdata;
          state_q <= S_MRG_SUM;
        end
        S_MRG_SUM: state_q <= S_MRG_LINK;
        S_MRG_LINK: begin
          first_q <= first_inc[PosBits-1:0];
          next_q  <= next_q + NodeBits'(1);
          if ((first_inc + (PosBits + 1)'(1)) < LastPosW + (PosBits + 1)'(1)
              && first_inc < LastPosW) begin
            state_q <= S_SORT;
          end else begin
            sym_q   <= '0;
            state_q <= S_WSTART;
          end
        end
        // Walk from the leaf up to the root, one tree level per step.
        S_WSTART: begin
          p_q     <= NodeBits'(sym_q);
          bits_q  <= '0;
          len_q   <= '0;
          state_q <= S_WALK;
        end
        S_WALK: state_q <= (p_q == RootNode) ? S_OUT : S_WSTEP;
        S_WSTEP: begin
          if (len_q < LenMax) begin
            if (!l_rdata[0]) begin
              bits_q <= bits_q | (CodeBits'(1) << len_q);
            end
            len_q <= len_q + LengthBits'(1);
          end
          p_q     <= l_rdata[LinkBits-1:1];
          state_q <= S_WALK;
        end
        S_OUT: begin
          if (out_load) begin
            out_valid_q   <= 1'b1;
            symbol_q      <= SymbolBits'(sym_q);
            code_bits_q   <= bits_q;
            code_length_q <= len_q;
            last_q        <= (sym_q == LastPos);
            if (sym_q == LastPos) begin
              state_q <= S_LOAD;
            end else begin
              sym_q   <= sym_q + PosBits'(1);
              state_q <= S_WSTART;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign in_ready_o    = (state_q == S_LOAD);
  assign out_valid_o   = out_valid_q;
  assign symbol_o      = symbol_q;
  assign code_bits_o   = code_bits_q;
  assign code_length_o = code_length_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

// File: design/hcb_checker.sv
// ----------------------------------------------------------------------------
// hcb_checker
// Port-level checks of the Huffman code builder, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "huffman_code_builder_assert.svh"

module hcb_checker
  import hcb_pkg::*;
#(
  parameter int unsigned NUM_SYMBOLS = DefAlphabetSize
) (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_ready_o,
  input wire logic                    out_valid_o,
  input wire logic                    out_ready_i,
  input wire logic [SymbolBits-1:0]   symbol_o,
  input wire logic [CodeBits-1:0]     code_bits_o,
  input wire logic [LengthBits-1:0]   code_length_o,
  input wire logic                    last_o
);

  localparam logic [SymbolBits-1:0] LastSym = SymbolBits'(NUM_SYMBOLS - 1);

  logic                                          out_stall;
  logic [SymbolBits+CodeBits+LengthBits:0]       out_beat;

  assign out_stall = out_valid_o && !out_ready_i;
  assign out_beat  = {symbol_o, code_bits_o, code_length_o, last_o};

  // A stalled code beat holds.
  `HCB_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable(out_beat), "code beat changed")

  // The final code belongs to the last symbol.
  `HCB_ASSERT_NOW(a_last_sym, out_valid_o && last_o, symbol_o == LastSym, "last on wrong symbol")

  // No weight is taken while codes of this alphabet are still coming.
  `HCB_ASSERT_NOW(a_busy, out_valid_o && !last_o, !in_ready_o, "weight taken during codes")

  // Every leaf sits below the root, so no code is empty.
  `HCB_ASSERT_NOW(a_len, out_valid_o, code_length_o != '0, "empty code emitted")

endmodule

bind huffman_code_builder hcb_checker #(.NUM_SYMBOLS(NUM_SYMBOLS)) u_hcb_checker (.*);

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Huffman code builder testbench
// Streams alphabets of symbol weights into the builder and checks every
// emitted code beat against a built-in model of the tree construction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import hcb_pkg::*;

  localparam int NumSym   = DefAlphabetSize;
  localparam int NumNodes = 2 * NumSym - 1;
  localparam int NoParent = 255;

  typedef struct packed {
    logic [SymbolBits-1:0] sym;
    logic [CodeBits-1:0]   bits;
    logic [LengthBits-1:0] len;
    logic                  lst;
  } code_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [InWeightBits-1:0] weight_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [SymbolBits-1:0] symbol_o;
  logic [CodeBits-1:0] code_bits_o;
  logic [LengthBits-1:0] code_length_o;
  logic last_o;

  // Model state.
  logic [NodeWeightBits-1:0] tree_wt [NumNodes];
  int unsigned tree_up [NumNodes];
  bit tree_left [NumNodes];
  int unsigned roots [NumSym];
  int unsigned loaded;

  code_beat_t expected_codes[$];
  int unsigned error_count;
  bit send_gaps;
  bit recv_gaps;
  int unsigned hold_cycles;

  huffman_code_builder u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .weight_i,
    .out_valid_o, .out_ready_i, .symbol_o, .code_bits_o, .code_length_o, .last_o
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR %0t: %s", $realtime, what);
    error_count++;
  endtask

  // Quicksort of the live roots, first element pivot, explicit range stack.
  function automatic void sort_live_roots(input int lo, input int hi);
    int stk_b[$];
    int stk_e[$];
    int b;
    int e;
    int i;
    int j;
    int unsigned pivot;
    int unsigned tmp;
    logic [NodeWeightBits-1:0] pw;
    if (lo < hi) begin
      stk_b.push_back(lo);
      stk_e.push_back(hi);
    end
    while (stk_b.size() > 0) begin
      b = stk_b.pop_back();
      e = stk_e.pop_back();
      pivot = roots[b];
      pw = tree_wt[pivot];
      i = b;
      j = e;
      while (i != j) begin
        while (tree_wt[roots[j]] >= pw && j > i) j--;
        while (tree_wt[roots[i]] <= pw && j > i) i++;
        if (j > i) begin
          tmp = roots[i];
          roots[i] = roots[j];
          roots[j] = tmp;
        end
      end
      roots[b] = roots[i];
      roots[i] = pivot;
      if (i + 1 < e && stk_b.size() < StackDepth) begin
        stk_b.push_back(i + 1);
        stk_e.push_back(e);
      end
      if (b < i - 1 && stk_b.size() < StackDepth) begin
        stk_b.push_back(b);
        stk_e.push_back(i - 1);
      end
    end
  endfunction

  // Loads one weight; on the last symbol builds the tree and queues codes.
  function automatic void predict_codes(input logic [InWeightBits-1:0] w);
    int first;
    int nxt;
    int unsigned a;
    int unsigned c;
    int unsigned p;
    code_beat_t beat;
    tree_wt[loaded] = NodeWeightBits'(w);
    loaded++;
    if (loaded < NumSym) return;
    loaded = 0;
    for (int n = 0; n < NumNodes; n++) begin
      tree_up[n] = NoParent;
      tree_left[n] = 1'b0;
    end
    for (int n = 0; n < NumSym; n++) roots[n] = n;
    first = 0;
    nxt = NumSym;
    while (first < NumSym - 1) begin
      sort_live_roots(first, NumSym - 1);
      a = roots[first];
      c = roots[first + 1];
      tree_wt[nxt] = tree_wt[a] + tree_wt[c];
      tree_up[a] = nxt;
      tree_up[c] = nxt;
      tree_left[a] = 1'b1;
      tree_left[c] = 1'b0;
      roots[first] = 0;
      roots[first + 1] = nxt;
      first++;
      nxt++;
    end
    for (int s = 0; s < NumSym; s++) begin
      beat = '0;
      beat.sym = SymbolBits'(s);
      p = s;
      while (tree_up[p] != NoParent) begin
        if (beat.len < CodeMax) begin
          if (!tree_left[p]) beat.bits[beat.len] = 1'b1;
          beat.len++;
        end
        p = tree_up[p];
      end
      beat.lst = (s == NumSym - 1);
      expected_codes.push_back(beat);
    end
  endfunction

  // Sends one weight beat, with an optional random gap first. Valid stays
  // high after the beat so that a following beat can go back to back.
  task automatic send_weight(input logic [InWeightBits-1:0] w);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    weight_i <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_codes(w);
  endtask

  // Stops offering weights and waits until every expected code has come.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_codes.size() > 0) @(posedge clk_i);
  endtask

  // Receiver ready: long hold-off when requested, else random stall bursts.
  // The hold-off only counts cycles in which a code beat is waiting.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        if (out_valid_o) hold_cycles--;
      end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Compares each accepted code beat with the oldest expectation.
  initial begin
    code_beat_t exp_beat;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (expected_codes.size() == 0) begin
          report_mismatch($sformatf("unexpected code beat for symbol %0d", symbol_o));
        end else begin
          exp_beat = expected_codes.pop_front();
          if (symbol_o !== exp_beat.sym)
            report_mismatch($sformatf("symbol %0d, expected %0d", symbol_o, exp_beat.sym));
          if (code_bits_o !== exp_beat.bits)
            report_mismatch($sformatf("symbol %0d code_bits %h, expected %h",
                                      exp_beat.sym, code_bits_o, exp_beat.bits));
          if (code_length_o !== exp_beat.len)
            report_mismatch($sformatf("symbol %0d code_length %0d, expected %0d",
                                      exp_beat.sym, code_length_o, exp_beat.len));
          if (last_o !== exp_beat.lst)
            report_mismatch($sformatf("symbol %0d last %b, expected %b",
                                      exp_beat.sym, last_o, exp_beat.lst));
        end
      end
    end
  end

  // Extremes in one alphabet: zero weights, full-scale ties and single bits.
  task automatic test_extremes();
    for (int s = 0; s < NumSym; s++) begin
      if (s < 8) send_weight('0);
      else if (s < 16) send_weight('1);
      else send_weight(InWeightBits'(1) << (s % InWeightBits));
    end
    wait_drained();
  endtask

  // Power-of-two skew gives deep codes; the receiver holds off meanwhile.
  task automatic test_deep_and_backpressure();
    logic [InWeightBits-1:0] w;
    hold_cycles = 600;
    for (int s = 0; s < NumSym; s++) begin
      w = (s < 23) ? InWeightBits'(1) << s : InWeightBits'($urandom);
      send_weight(w);
    end
    // Keep offering the next alphabet while the output is still blocked.
    for (int s = 0; s < NumSym; s++) send_weight(InWeightBits'($urandom_range(0, 7)));
    wait_drained();
  endtask

  // Random alphabets with mixed distributions.
  task automatic test_random(input int n_alpha);
    int mode;
    for (int k = 0; k < n_alpha; k++) begin
      mode = $urandom_range(0, 2);
      for (int s = 0; s < NumSym; s++) begin
        case (mode)
          0: send_weight(InWeightBits'($urandom));
          1: send_weight(InWeightBits'($urandom_range(0, 4)));
          default: send_weight(InWeightBits'($urandom) >> $urandom_range(0, 23));
        endcase
      end
      if ($urandom_range(0, 1) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    loaded = 0;
    error_count = 0;
    hold_cycles = 0;
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    test_deep_and_backpressure();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    test_random(1);
    repeat (200) @(posedge clk_i);
    if (error_count == 0 && expected_codes.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
